// ===== sv/auto_gain_exposure_control_top_defines.svh =====
// Assertion macros shared by the RTL files of the gain and exposure control block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef AUTO_GAIN_EXPOSURE_CONTROL_TOP_DEFINES_SVH
`define AUTO_GAIN_EXPOSURE_CONTROL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge outside reset.
`define AGEC_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("agec: assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define AGEC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("agec: assertion failed");

// A condition that must hold in the cycle after its trigger.
`define AGEC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("agec: assertion failed");

`else

`define AGEC_ASSERT(name, clk, rst, expr)
`define AGEC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define AGEC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== sv/agec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package agec_pkg;

   // Default frame size limits.
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   // Field and register widths.
   localparam int PIXEL_W  = 8;
   localparam int SUM_W    = 32;
   localparam int AVG_W    = 9;
   localparam int GAIN_W   = 6;
   localparam int EXPO_W   = 10;
   localparam int FSIZE_W  = 12;
   localparam int REGION_W = 11;
   localparam int THRESH_W = 8;
   localparam int CSR_W    = 12;
   localparam int CSR_IDX_W = 3;

   // The average saturates below 2^AVG_SHIFT.
   localparam int AVG_SHIFT = 9;

   // Depth of the queue between the pixel front end and the control back end.
   localparam int QUEUE_DEPTH = 2;

   // Controller constants.
   localparam logic [AVG_W-1:0]  AVG_CAP   = 9'd511;
   localparam logic [GAIN_W-1:0] GAIN_CAP  = 6'd50;
   localparam logic [EXPO_W-1:0] EXPO_CAP  = 10'd1023;
   localparam logic [EXPO_W-1:0] EXPO_HIGH = 10'd220;
   localparam logic [EXPO_W-1:0] EXPO_LOW  = 10'd125;
   localparam logic [EXPO_W-1:0] EXPO_STEP = 10'd5;

   // Register values after reset.
   localparam logic [FSIZE_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
   localparam logic [FSIZE_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
   localparam logic [REGION_W-1:0] REGION_LIMIT_RST = 11'd50;
   localparam logic [THRESH_W-1:0] BRIGHT_RST       = 8'd50;
   localparam logic [THRESH_W-1:0] DARK_RST         = 8'd30;
   localparam logic [GAIN_W-1:0]   GAIN_RST         = 6'd25;
   localparam logic [EXPO_W-1:0]   EXPO_RST         = 10'd150;

   // Register map.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH      = 3'd0,
      CSR_FRAME_HEIGHT     = 3'd1,
      CSR_REGION_LIMIT     = 3'd2,
      CSR_BRIGHT_THRESHOLD = 3'd3,
      CSR_DARK_THRESHOLD   = 3'd4,
      CSR_INITIAL_GAIN     = 3'd5,
      CSR_INITIAL_EXPOSURE = 3'd6
   } csr_index_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_STEP
   } back_state_type;

   // Settings that the back end reads.
   typedef struct packed {
      logic [REGION_W-1:0] region_limit;
      logic [THRESH_W-1:0] bright_threshold;
      logic [THRESH_W-1:0] dark_threshold;
   } back_cfg_type;

   // Preset loads of the gain and exposure levels.
   typedef struct packed {
      logic              gain_we;
      logic [GAIN_W-1:0] gain;
      logic              expo_we;
      logic [EXPO_W-1:0] expo;
   } level_load_type;

endpackage
`default_nettype wire

// ===== sv/auto_gain_exposure_control_top.sv =====
// Auto gain and exposure control. Gray pixels stream in raster order on the req_ channel
// and are taken one word per clock while the queue is not full; the pixel front end tracks
// column and row against the configured frame size and sums the pixels of columns 0 through
// region_limit. At the last pixel of a frame the sum enters a two-entry queue, and the back
// end works it off while the next frame streams in: it pops the sum, forms region_limit times
// frame height in one multiply, checks the average against its cap of 511, runs a restoring
// divider one quotient bit per cycle, and applies one gain/exposure step once the rsp_ output
// is free, giving one rsp_ word per frame. The serial divider limits how fast frames are
// worked off, so short frames fill the queue and req_ready drops until an entry frees up.
// Registers must be written through the csr_ port only while the block is idle; the block
// does not enforce this. Writing initial_gain or initial_exposure also loads the live level.
`timescale 1ns / 1ps
`default_nettype none
module auto_gain_exposure_control_top #(
   parameter int MAX_WIDTH  = agec_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = agec_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [agec_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [agec_pkg::AVG_W-1:0]             rsp_average,
   output logic [agec_pkg::GAIN_W-1:0]            rsp_gain_out,
   output logic [agec_pkg::EXPO_W-1:0]            rsp_exposure_out,
   output logic                                   rsp_gain_written,
   output logic                                   rsp_exposure_written,
   input  wire logic                              csr_write_enable,
   input  wire logic [agec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [agec_pkg::CSR_W-1:0]        csr_write_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [agec_pkg::FSIZE_W-1:0]  frame_width_ff, frame_width_in;
   logic [agec_pkg::FSIZE_W-1:0]  frame_height_ff, frame_height_in;
   logic [agec_pkg::REGION_W-1:0] region_limit_ff, region_limit_in;
   logic [agec_pkg::THRESH_W-1:0] bright_ff, bright_in;
   logic [agec_pkg::THRESH_W-1:0] dark_ff, dark_in;

   logic [WW-1:0]                 eff_width;
   logic [HW-1:0]                 eff_height;
   agec_pkg::back_cfg_type        back_cfg;
   agec_pkg::level_load_type      level_load;

   logic                          push;
   logic [agec_pkg::SUM_W-1:0]    push_sum;
   logic                          pop;
   logic [agec_pkg::SUM_W-1:0]    pop_sum;
   logic                          queue_full;
   logic                          queue_empty;

   // Register writes; preset registers only load the live levels in the back end.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      region_limit_in = region_limit_ff;
      bright_in       = bright_ff;
      dark_in         = dark_ff;
      level_load      = '0;
      level_load.gain = csr_write_data[agec_pkg::GAIN_W-1:0];
      level_load.expo = csr_write_data[agec_pkg::EXPO_W-1:0];
      if (csr_write_enable) begin
         unique case (agec_pkg::csr_index_type'(csr_index))
            agec_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_write_data[agec_pkg::FSIZE_W-1:0];
            end
            agec_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_write_data[agec_pkg::FSIZE_W-1:0];
            end
            agec_pkg::CSR_REGION_LIMIT: begin
               region_limit_in = csr_write_data[agec_pkg::REGION_W-1:0];
            end
            agec_pkg::CSR_BRIGHT_THRESHOLD: begin
               bright_in = csr_write_data[agec_pkg::THRESH_W-1:0];
            end
            agec_pkg::CSR_DARK_THRESHOLD: begin
               dark_in = csr_write_data[agec_pkg::THRESH_W-1:0];
            end
            agec_pkg::CSR_INITIAL_GAIN: begin
               level_load.gain_we = 1'b1;
            end
            agec_pkg::CSR_INITIAL_EXPOSURE: begin
               level_load.expo_we = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= agec_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= agec_pkg::FRAME_HEIGHT_RST;
         region_limit_ff <= agec_pkg::REGION_LIMIT_RST;
         bright_ff       <= agec_pkg::BRIGHT_RST;
         dark_ff         <= agec_pkg::DARK_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         region_limit_ff <= region_limit_in;
         bright_ff       <= bright_in;
         dark_ff         <= dark_in;
      end
   end

   // Frame size clamped to one through the supported maximum.
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = WW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_height = HW'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_height = HW'(MAX_HEIGHT);
      end else begin
         eff_height = HW'(frame_height_ff);
      end
   end

   assign back_cfg.region_limit     = region_limit_ff;
   assign back_cfg.bright_threshold = bright_ff;
   assign back_cfg.dark_threshold   = dark_ff;

   agec_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel    (req_pixel),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .region_limit (region_limit_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_sum     (push_sum)
   );

   agec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_sum),
      .pop       (pop),
      .pop_data  (pop_sum),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   agec_back #(
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_empty          (queue_empty),
      .pop                  (pop),
      .pop_sum              (pop_sum),
      .eff_height           (eff_height),
      .cfg                  (back_cfg),
      .load                 (level_load),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_average          (rsp_average),
      .rsp_gain_out         (rsp_gain_out),
      .rsp_exposure_out     (rsp_exposure_out),
      .rsp_gain_written     (rsp_gain_written),
      .rsp_exposure_written (rsp_exposure_written)
   );

endmodule
`default_nettype wire

// ===== sv/agec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module agec_front #(
   parameter int MAX_WIDTH  = agec_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = agec_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [agec_pkg::PIXEL_W-1:0]       req_pixel,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     eff_width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    eff_height,
   input  wire logic [agec_pkg::REGION_W-1:0]      region_limit,
   input  wire logic                               queue_full,
   output logic                                    push,
   output logic [agec_pkg::SUM_W-1:0]              push_sum
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int SW = agec_pkg::SUM_W;

   logic [WW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [SW-1:0] sum_ff, sum_in;

   logic                         accept;
   logic                         in_region;
   logic                         row_end;
   logic                         frame_end;
   logic [agec_pkg::PIXEL_W-1:0] pix_masked;
   logic [SW:0]                  sum_wide;
   logic [SW-1:0]                sum_sat;

   // A word is taken whenever the queue can hold a possible frame result.
   assign accept    = req_valid && !queue_full;
   assign req_ready = !queue_full;

   // Saturating region sum and raster position decode.
   always_comb begin
      in_region  = 32'(col_ff) <= 32'(region_limit);
      pix_masked = in_region ? req_pixel : '0;
      sum_wide   = (SW+1)'(sum_ff) + (SW+1)'(pix_masked);
      sum_sat    = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
      row_end    = ((WW+1)'(col_ff) + (WW+1)'(1)) >= (WW+1)'(eff_width);
      frame_end  = row_end && (((HW+1)'(row_ff) + (HW+1)'(1)) >= (HW+1)'(eff_height));
   end

   // Counter and sum update for each accepted word.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            sum_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + HW'(1);
            sum_in = sum_sat;
         end else begin
            col_in = col_ff + WW'(1);
            sum_in = sum_sat;
         end
      end
   end

   // The last pixel of a frame hands the finished sum to the queue.
   assign push     = accept && frame_end;
   assign push_sum = sum_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sum_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/agec_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "auto_gain_exposure_control_top_defines.svh"
module agec_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [agec_pkg::SUM_W-1:0]    push_data,
   input  wire logic                          pop,
   output logic [agec_pkg::SUM_W-1:0]         pop_data,
   output logic                               full,
   output logic                               empty
);

   localparam int DEPTH = agec_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [agec_pkg::SUM_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]              count_ff, count_in;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `AGEC_ASSERT_IMPL(a_queue_no_overflow, clock, reset, push, !full)
   `AGEC_ASSERT_IMPL(a_queue_no_underflow, clock, reset, pop, !empty)

endmodule
`default_nettype wire

// ===== sv/agec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "auto_gain_exposure_control_top_defines.svh"
module agec_back #(
   parameter int MAX_HEIGHT = agec_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               queue_empty,
   output logic                                    pop,
   input  wire logic [agec_pkg::SUM_W-1:0]         pop_sum,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    eff_height,
   input  wire agec_pkg::back_cfg_type             cfg,
   input  wire agec_pkg::level_load_type           load,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [agec_pkg::AVG_W-1:0]              rsp_average,
   output logic [agec_pkg::GAIN_W-1:0]             rsp_gain_out,
   output logic [agec_pkg::EXPO_W-1:0]             rsp_exposure_out,
   output logic                                    rsp_gain_written,
   output logic                                    rsp_exposure_written
);

   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DW    = agec_pkg::REGION_W + HW;
   localparam int XW    = (DW + agec_pkg::AVG_SHIFT > agec_pkg::SUM_W) ?
                          DW + agec_pkg::AVG_SHIFT : agec_pkg::SUM_W;
   localparam int NW    = $clog2(agec_pkg::AVG_SHIFT + 1);
   localparam int AW    = agec_pkg::AVG_W;
   localparam int GW    = agec_pkg::GAIN_W;
   localparam int EW    = agec_pkg::EXPO_W;

   agec_pkg::back_state_type state_ff, state_in;

   logic [XW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [XW-1:0] sh_ff, sh_in;
   logic [AW-1:0] quo_ff, quo_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [GW-1:0] gain_ff, gain_in;
   logic [EW-1:0] expo_ff, expo_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_average_ff, rsp_average_in;
   logic [GW-1:0] rsp_gain_ff, rsp_gain_in;
   logic [EW-1:0] rsp_expo_ff, rsp_expo_in;
   logic          rsp_gw_ff, rsp_gw_in;
   logic          rsp_ew_ff, rsp_ew_in;

   logic [GW-1:0] gain_step;
   logic [EW-1:0] expo_step;
   logic          gw_step;
   logic          ew_step;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // One control step from the finished average.
   always_comb begin
      gain_step = gain_ff;
      expo_step = expo_ff;
      gw_step   = 1'b0;
      ew_step   = 1'b0;
      if (quo_ff > AW'(cfg.bright_threshold)) begin
         if (expo_ff > agec_pkg::EXPO_HIGH) begin
            expo_step = expo_ff - agec_pkg::EXPO_STEP;
            ew_step   = 1'b1;
         end else begin
            if (gain_ff == '0) begin
               expo_step = (expo_ff >= agec_pkg::EXPO_STEP) ?
                           expo_ff - agec_pkg::EXPO_STEP : '0;
               ew_step   = 1'b1;
            end else begin
               gain_step = gain_ff - GW'(1);
            end
            gw_step = 1'b1;
         end
      end else if (quo_ff < AW'(cfg.dark_threshold)) begin
         if (expo_ff < agec_pkg::EXPO_LOW) begin
            expo_step = expo_ff + agec_pkg::EXPO_STEP;
            ew_step   = 1'b1;
         end else begin
            if (gain_ff >= agec_pkg::GAIN_CAP) begin
               gain_step = agec_pkg::GAIN_CAP;
               expo_step = (expo_ff > agec_pkg::EXPO_CAP - agec_pkg::EXPO_STEP) ?
                           agec_pkg::EXPO_CAP : expo_ff + agec_pkg::EXPO_STEP;
               ew_step   = 1'b1;
            end else begin
               gain_step = gain_ff + GW'(1);
            end
            gw_step = 1'b1;
         end
      end
   end

   // Sequencer: take a sum, form the divisor, divide one bit a cycle, then step.
   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      sh_in          = sh_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      gain_in        = gain_ff;
      expo_in        = expo_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_average_in = rsp_average_ff;
      rsp_gain_in    = rsp_gain_ff;
      rsp_expo_in    = rsp_expo_ff;
      rsp_gw_in      = rsp_gw_ff;
      rsp_ew_in      = rsp_ew_ff;
      pop            = 1'b0;
      unique case (state_ff)
         agec_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               rem_in   = XW'(pop_sum);
               state_in = agec_pkg::ST_MUL;
            end
         end
         agec_pkg::ST_MUL: begin
            div_in   = DW'(cfg.region_limit) * DW'(eff_height);
            state_in = agec_pkg::ST_CHECK;
         end
         agec_pkg::ST_CHECK: begin
            // A zero divisor or a quotient past the cap reads as the cap.
            if (div_ff == '0 || rem_ff >= (XW'(div_ff) << agec_pkg::AVG_SHIFT)) begin
               quo_in   = agec_pkg::AVG_CAP;
               state_in = agec_pkg::ST_STEP;
            end else begin
               sh_in    = XW'(div_ff) << (agec_pkg::AVG_SHIFT - 1);
               quo_in   = '0;
               cnt_in   = NW'(agec_pkg::AVG_SHIFT);
               state_in = agec_pkg::ST_DIV;
            end
         end
         agec_pkg::ST_DIV: begin
            if (rem_ff >= sh_ff) begin
               rem_in = rem_ff - sh_ff;
               quo_in = {quo_ff[AW-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[AW-2:0], 1'b0};
            end
            sh_in  = sh_ff >> 1;
            cnt_in = cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               state_in = agec_pkg::ST_STEP;
            end
         end
         agec_pkg::ST_STEP: begin
            if (out_free) begin
               gain_in        = gain_step;
               expo_in        = expo_step;
               rsp_valid_in   = 1'b1;
               rsp_average_in = quo_ff;
               rsp_gain_in    = gain_step;
               rsp_expo_in    = expo_step;
               rsp_gw_in      = gw_step;
               rsp_ew_in      = ew_step;
               state_in       = agec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = agec_pkg::ST_IDLE;
         end
      endcase
      // Preset writes load the levels directly; a gain preset above the cap loads the cap.
      if (load.gain_we) begin
         gain_in = (load.gain > agec_pkg::GAIN_CAP) ? agec_pkg::GAIN_CAP : load.gain;
      end
      if (load.expo_we) begin
         expo_in = load.expo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= agec_pkg::ST_IDLE;
         gain_ff      <= agec_pkg::GAIN_RST;
         expo_ff      <= agec_pkg::EXPO_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         expo_ff      <= expo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      sh_ff          <= sh_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_average_ff <= rsp_average_in;
      rsp_gain_ff    <= rsp_gain_in;
      rsp_expo_ff    <= rsp_expo_in;
      rsp_gw_ff      <= rsp_gw_in;
      rsp_ew_ff      <= rsp_ew_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_average          = rsp_average_ff;
   assign rsp_gain_out         = rsp_gain_ff;
   assign rsp_exposure_out     = rsp_expo_ff;
   assign rsp_gain_written     = rsp_gw_ff;
   assign rsp_exposure_written = rsp_ew_ff;

   `AGEC_ASSERT(a_gain_in_range, clock, reset, gain_ff <= agec_pkg::GAIN_CAP)
   `AGEC_ASSERT_IMPL(a_div_nonzero, clock, reset, state_ff == agec_pkg::ST_DIV, div_ff != '0)
   `AGEC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_ready, rsp_average_ff == $past(rsp_average_ff) && rsp_expo_ff == $past(rsp_expo_ff))

endmodule
`default_nettype wire

// ===== tb/tb_auto_gain_exposure_control_top.sv =====
`timescale 1ns / 1ps
module tb_auto_gain_exposure_control_top;
   import agec_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PIXELS = 320;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   // Pixel value mixes for the random frames.
   typedef enum int {
      MIX_UNIFORM,
      MIX_DARK,
      MIX_BRIGHT,
      MIX_EXTREME
   } pixel_mix_type;

   // One frame-end word as the block should report it.
   typedef struct {
      logic [AVG_W-1:0]  average;
      logic [GAIN_W-1:0] gain;
      logic [EXPO_W-1:0] exposure;
      logic              gain_written;
      logic              exposure_written;
   } frame_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIXEL_W-1:0]   req_pixel = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [AVG_W-1:0]     rsp_average;
   logic [GAIN_W-1:0]    rsp_gain_out;
   logic [EXPO_W-1:0]    rsp_exposure_out;
   logic                 rsp_gain_written;
   logic                 rsp_exposure_written;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // Shadow copy of the registers and of the raster and control state.
   logic [FSIZE_W-1:0]  cfg_width      = FRAME_WIDTH_RST;
   logic [FSIZE_W-1:0]  cfg_height     = FRAME_HEIGHT_RST;
   logic [REGION_W-1:0] cfg_region     = REGION_LIMIT_RST;
   logic [THRESH_W-1:0] cfg_bright     = BRIGHT_RST;
   logic [THRESH_W-1:0] cfg_dark       = DARK_RST;
   logic [GAIN_W-1:0]   gain_level     = GAIN_RST;
   logic [EXPO_W-1:0]   exposure_level = EXPO_RST;
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;
   logic [SUM_W-1:0]    region_acc = '0;

   frame_step_type pending_frame_steps[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          rx_hold_request = 0;
   int          rx_hold_left = 0;
   bit          idling_on = 1'b1;
   bit          block_settled = 1'b1;

   auto_gain_exposure_control_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_pixel            (req_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_average          (rsp_average),
      .rsp_gain_out         (rsp_gain_out),
      .rsp_exposure_out     (rsp_exposure_out),
      .rsp_gain_written     (rsp_gain_written),
      .rsp_exposure_written (rsp_exposure_written),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always #10 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("auto_gain_exposure_control_top verification failed");
         $finish;
      end
   end

   // Result side: a long hold-off on request, otherwise random stalls.
   always @(posedge clock) begin
      if (rx_hold_request > 0) begin
         rx_hold_left = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left--;
      end else if (idling_on && $urandom_range(99) < 8) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare one field and report it when it differs.
   task automatic report_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // Every accepted result word is checked against the oldest predicted step.
   always @(posedge clock) begin : check_results
      frame_step_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frame_steps.size() == 0) begin
            mismatch_count++;
            $display("%0t: result word with none expected, expected none, actual average %0d",
                     $time, rsp_average);
         end else begin
            want = pending_frame_steps.pop_front();
            report_field("average", 16'(want.average), 16'(rsp_average));
            report_field("gain_out", 16'(want.gain), 16'(rsp_gain_out));
            report_field("exposure_out", 16'(want.exposure), 16'(rsp_exposure_out));
            report_field("gain_written", 16'(want.gain_written), 16'(rsp_gain_written));
            report_field("exposure_written", 16'(want.exposure_written),
                         16'(rsp_exposure_written));
         end
      end
   end

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Advance the raster by one pixel; at a frame end, run the control step
   // and queue the word the block should produce.
   task automatic advance_raster(input logic [PIXEL_W-1:0] px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     expo_up;
      longint unsigned total;
      longint unsigned divisor;
      longint unsigned avg;
      bit              row_end;
      bit              frame_end;
      frame_step_type  step;
      w = clamp_size(32'(cfg_width), MAX_WIDTH_DEF);
      h = clamp_size(32'(cfg_height), MAX_HEIGHT_DEF);
      if (col_pos <= cfg_region) begin
         total = 64'(region_acc) + 64'(px);
         region_acc = (total > 64'hFFFF_FFFF) ? '1 : SUM_W'(total);
      end
      // A counter past a shrunken size ends its row or frame right here.
      row_end = (col_pos + 1 >= w);
      frame_end = row_end && (row_pos + 1 >= h);
      if (!frame_end) begin
         if (row_end) begin
            col_pos = 0;
            row_pos++;
         end else begin
            col_pos++;
         end
         return;
      end

      // A zero divisor and any large quotient both read as the cap.
      divisor = 64'(cfg_region) * 64'(h);
      if (divisor == 0) begin
         avg = 64'(AVG_CAP);
      end else begin
         avg = 64'(region_acc) / divisor;
         if (avg > AVG_CAP) avg = 64'(AVG_CAP);
      end

      step.gain_written = 1'b0;
      step.exposure_written = 1'b0;
      if (avg > cfg_bright) begin
         if (exposure_level > EXPO_HIGH) begin
            exposure_level -= EXPO_STEP;
            step.exposure_written = 1'b1;
         end else begin
            // Gain already at zero: exposure takes the step, floored at zero.
            if (gain_level == 0) begin
               exposure_level = (exposure_level >= EXPO_STEP) ? exposure_level - EXPO_STEP : '0;
               step.exposure_written = 1'b1;
            end else begin
               gain_level--;
            end
            step.gain_written = 1'b1;
         end
      end else if (avg < cfg_dark) begin
         if (exposure_level < EXPO_LOW) begin
            exposure_level += EXPO_STEP;
            step.exposure_written = 1'b1;
         end else begin
            // Gain at its cap: exposure takes the step, capped at full scale.
            if (gain_level >= GAIN_CAP) begin
               gain_level = GAIN_CAP;
               expo_up = 32'(exposure_level) + 32'(EXPO_STEP);
               exposure_level = (expo_up > EXPO_CAP) ? EXPO_CAP : EXPO_W'(expo_up);
               step.exposure_written = 1'b1;
            end else begin
               gain_level++;
            end
            step.gain_written = 1'b1;
         end
      end

      col_pos = 0;
      row_pos = 0;
      region_acc = '0;
      step.average = AVG_W'(avg);
      step.gain = gain_level;
      step.exposure = exposure_level;
      pending_frame_steps.push_back(step);
   endtask

   // Stop offering pixels, wait for every predicted word, then let the
   // block finish any work that produces no word.
   task automatic wait_for_results_drained();
      req_valid <= 1'b0;
      while (pending_frame_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      block_settled = 1'b1;
   endtask

   // Write one register while the block is idle and track it in the shadow.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0] data);
      if (!block_settled) wait_for_results_drained();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:      cfg_width = data[FSIZE_W-1:0];
         CSR_FRAME_HEIGHT:     cfg_height = data[FSIZE_W-1:0];
         CSR_REGION_LIMIT:     cfg_region = data[REGION_W-1:0];
         CSR_BRIGHT_THRESHOLD: cfg_bright = data[THRESH_W-1:0];
         CSR_DARK_THRESHOLD:   cfg_dark = data[THRESH_W-1:0];
         CSR_INITIAL_GAIN:
            gain_level = (data[GAIN_W-1:0] > GAIN_CAP) ? GAIN_CAP : data[GAIN_W-1:0];
         CSR_INITIAL_EXPOSURE: exposure_level = data[EXPO_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one pixel word, now and then after dropping req_valid first, and wait for
   // it to be taken.
   task automatic offer_pixel(input logic [PIXEL_W-1:0] px);
      block_settled = 1'b0;
      if (idling_on && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      advance_raster(px);
   endtask

   function automatic logic [PIXEL_W-1:0] draw_pixel(input pixel_mix_type mix);
      case (mix)
         MIX_DARK:   return PIXEL_W'($urandom_range(40));
         MIX_BRIGHT: return PIXEL_W'($urandom_range(255, 200));
         MIX_EXTREME: return $urandom_range(1) ? 8'd255 : 8'd0;
         default:    return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   // Register value with random junk above the register's width now and then.
   function automatic logic [CSR_W-1:0] with_junk(input int unsigned val, input int bits);
      logic [CSR_W-1:0] mask;
      mask = (CSR_W'(1) << bits) - 1'b1;
      return (CSR_W'(val) & mask) | (($urandom_range(3) == 0) ? (CSR_W'($urandom) & ~mask) : '0);
   endfunction

   function automatic int unsigned draw_threshold();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 0;
      if (roll == 1) return 255;
      return $urandom_range(255);
   endfunction

   // Pick a new random setting; frame sizes are mostly small.
   task automatic choose_random_settings();
      int unsigned w;
      int unsigned h;
      int unsigned roll;
      int unsigned region;
      roll = $urandom_range(99);
      if (roll < 70) w = $urandom_range(6, 1);
      else if (roll < 85) w = $urandom_range(40, 7);
      else if (roll < 95) w = 0;
      else w = $urandom_range(4095, 2048);
      roll = $urandom_range(99);
      if (roll < 70) h = $urandom_range(4, 1);
      else if (roll < 85) h = $urandom_range(10, 5);
      else if (roll < 95) h = 0;
      else h = $urandom_range(4095, 2048);
      roll = $urandom_range(99);
      if (roll < 60) region = $urandom_range(w + 1);
      else if (roll < 80) region = $urandom_range(2047);
      else if (roll < 90) region = 0;
      else region = 2047;

      if ($urandom_range(3) != 0) write_register(CSR_FRAME_WIDTH, CSR_W'(w));
      if ($urandom_range(3) != 0) write_register(CSR_FRAME_HEIGHT, CSR_W'(h));
      if ($urandom_range(1)) write_register(CSR_REGION_LIMIT, with_junk(region, REGION_W));
      if ($urandom_range(1))
         write_register(CSR_BRIGHT_THRESHOLD, with_junk(draw_threshold(), THRESH_W));
      if ($urandom_range(1))
         write_register(CSR_DARK_THRESHOLD, with_junk(draw_threshold(), THRESH_W));
      if ($urandom_range(9) < 3)
         write_register(CSR_INITIAL_GAIN, with_junk($urandom_range(63), GAIN_W));
      if ($urandom_range(9) < 3) begin
         roll = $urandom_range(9);
         write_register(CSR_INITIAL_EXPOSURE,
                        with_junk(roll == 0 ? 0 : roll == 1 ? 1023 : $urandom_range(1023),
                                  EXPO_W));
      end
      if ($urandom_range(19) == 0) write_register(CSR_UNMAPPED, CSR_W'($urandom_range(4095)));
   endtask

   // Reset values of every register except the frame size.
   task automatic test_reset_defaults();
      write_register(CSR_FRAME_WIDTH, 4);
      write_register(CSR_FRAME_HEIGHT, 2);
      repeat (8) offer_pixel(8'd255);
      repeat (8) offer_pixel(draw_pixel(MIX_UNIFORM));
   endtask

   // One-pixel frames so the average equals the pixel; walks each branch
   // of the control step, including both saturations.
   task automatic test_control_paths();
      write_register(CSR_FRAME_WIDTH, 1);
      write_register(CSR_FRAME_HEIGHT, 1);
      write_register(CSR_REGION_LIMIT, 1);
      write_register(CSR_BRIGHT_THRESHOLD, 100);
      write_register(CSR_DARK_THRESHOLD, 50);
      write_register(CSR_INITIAL_GAIN, 63);
      write_register(CSR_INITIAL_EXPOSURE, 1021);
      offer_pixel(8'd0);
      offer_pixel(8'd0);
      offer_pixel(8'd255);
      write_register(CSR_INITIAL_EXPOSURE, 222);
      offer_pixel(8'd255);
      offer_pixel(8'd255);
      write_register(CSR_INITIAL_GAIN, 0);
      write_register(CSR_INITIAL_EXPOSURE, 3);
      offer_pixel(8'd255);
      offer_pixel(8'd255);
      write_register(CSR_INITIAL_EXPOSURE, 120);
      offer_pixel(8'd0);
      offer_pixel(8'd0);
      // In band, on each threshold, and just past each one.
      offer_pixel(8'd75);
      offer_pixel(8'd100);
      offer_pixel(8'd50);
      offer_pixel(8'd101);
      offer_pixel(8'd49);
   endtask

   // A zero region limit gives a zero divisor.
   task automatic test_zero_region();
      write_register(CSR_REGION_LIMIT, 0);
      write_register(CSR_FRAME_WIDTH, 3);
      write_register(CSR_BRIGHT_THRESHOLD, 255);
      offer_pixel(8'd0);
      offer_pixel(8'd255);
      offer_pixel(8'd7);
   endtask

   // Zero sizes behave as one.
   task automatic test_size_clamp();
      write_register(CSR_FRAME_WIDTH, 0);
      write_register(CSR_FRAME_HEIGHT, 0);
      write_register(CSR_REGION_LIMIT, 1);
      write_register(CSR_BRIGHT_THRESHOLD, 128);
      write_register(CSR_DARK_THRESHOLD, 64);
      offer_pixel(8'd200);
      offer_pixel(8'd10);
      offer_pixel(8'd90);
   endtask

   // Shrink the width and then the height in the middle of a frame.
   task automatic test_mid_frame_resize();
      write_register(CSR_FRAME_WIDTH, 8);
      write_register(CSR_FRAME_HEIGHT, 2);
      write_register(CSR_REGION_LIMIT, 7);
      repeat (5) offer_pixel(draw_pixel(MIX_UNIFORM));
      write_register(CSR_FRAME_WIDTH, 3);
      repeat (4) offer_pixel(draw_pixel(MIX_UNIFORM));
      write_register(CSR_FRAME_WIDTH, 2);
      write_register(CSR_FRAME_HEIGHT, 4);
      repeat (5) offer_pixel(draw_pixel(MIX_UNIFORM));
      write_register(CSR_FRAME_HEIGHT, 2);
      offer_pixel(draw_pixel(MIX_UNIFORM));
   endtask

   // A write to an unmapped index changes nothing.
   task automatic test_unknown_index();
      write_register(CSR_UNMAPPED, 12'hFFF);
      repeat (4) offer_pixel(draw_pixel(MIX_EXTREME));
   endtask

   // Oversized width and height with the widest region and the threshold
   // extremes; the frames are ended early by shrinking the size mid-frame.
   task automatic test_size_extremes();
      write_register(CSR_FRAME_WIDTH, 4095);
      write_register(CSR_FRAME_HEIGHT, 4095);
      write_register(CSR_REGION_LIMIT, 2047);
      write_register(CSR_BRIGHT_THRESHOLD, 0);
      repeat (12) offer_pixel(draw_pixel(MIX_BRIGHT));
      write_register(CSR_FRAME_HEIGHT, 1);
      write_register(CSR_FRAME_WIDTH, 2);
      offer_pixel(draw_pixel(MIX_BRIGHT));
      write_register(CSR_FRAME_WIDTH, 1);
      write_register(CSR_FRAME_HEIGHT, 4095);
      write_register(CSR_REGION_LIMIT, 1);
      write_register(CSR_BRIGHT_THRESHOLD, 255);
      write_register(CSR_DARK_THRESHOLD, 255);
      repeat (6) offer_pixel(draw_pixel(MIX_UNIFORM));
      write_register(CSR_FRAME_HEIGHT, 3);
      offer_pixel(draw_pixel(MIX_UNIFORM));
   endtask

   // Hold off the result side for a long stretch while two-pixel frames
   // keep coming, so the queue fills and the input stalls.
   task automatic test_back_pressure();
      write_register(CSR_FRAME_WIDTH, 2);
      write_register(CSR_FRAME_HEIGHT, 1);
      write_register(CSR_REGION_LIMIT, 1);
      write_register(CSR_BRIGHT_THRESHOLD, 150);
      write_register(CSR_DARK_THRESHOLD, 100);
      idling_on = 1'b0;
      rx_hold_request = 300;
      repeat (100) offer_pixel(draw_pixel(MIX_UNIFORM));
      idling_on = 1'b1;
   endtask

   // Pause the pixel stream until every word is back, then resume.
   task automatic test_pause_until_drained();
      write_register(CSR_FRAME_WIDTH, 3);
      write_register(CSR_FRAME_HEIGHT, 2);
      write_register(CSR_REGION_LIMIT, 2);
      repeat (18) offer_pixel(draw_pixel(MIX_UNIFORM));
      wait_for_results_drained();
      repeat (18) offer_pixel(draw_pixel(MIX_UNIFORM));
   endtask

   // A stretch with no idling on either side.
   task automatic test_no_idle_stretch();
      write_register(CSR_FRAME_WIDTH, 3);
      write_register(CSR_FRAME_HEIGHT, 2);
      write_register(CSR_REGION_LIMIT, 2);
      idling_on = 1'b0;
      repeat (150) offer_pixel(draw_pixel(MIX_UNIFORM));
      idling_on = 1'b1;
   endtask

   // Random settings, each followed by a run of pixels from one mix.
   task automatic test_random_frames();
      int unsigned   sent;
      int unsigned   count;
      pixel_mix_type mix;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         choose_random_settings();
         mix = pixel_mix_type'($urandom_range(3));
         count = $urandom_range(80, 20);
         repeat (count) offer_pixel(draw_pixel(mix));
         sent += count;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_reset_defaults();
      test_control_paths();
      test_zero_region();
      test_size_clamp();
      test_mid_frame_resize();
      test_unknown_index();
      test_size_extremes();
      test_back_pressure();
      test_pause_until_drained();
      test_no_idle_stretch();
      test_random_frames();

      wait_for_results_drained();
      if (mismatch_count == 0 && pending_frame_steps.size() == 0) begin
         $display("auto_gain_exposure_control_top verification clean");
      end else begin
         $display("auto_gain_exposure_control_top verification failed");
      end
      $finish;
   end

endmodule
